@@ design/ccfd_pkg.sv @@
// shared types, constants and crc tables for the crc-8 checked frame deframer
`default_nettype none

package ccfd_pkg;

    // register indexes on the configuration port
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_TAG       = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_ENABLED_OPCODES = 1'b1;
    localparam int unsigned CfgDataW = 16;

    // register reset values
    localparam logic [7:0]  FRAME_TAG_RESET       = 8'hA5;
    localparam logic [15:0] ENABLED_OPCODES_RESET = 16'hA42A;

    // default depth of the queue between framer and output stage
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // widths of the stream ports
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 24;

    // framing phase
    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_OPCODE  = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } phase_t;

    // result kind
    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    // frame verdict
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_TAG   = 3'd1,
        ST_BAD_CRC   = 3'd2,
        ST_NIB_DIFF  = 3'd3,
        ST_UNHANDLED = 3'd4
    } status_t;

    // one result item as it travels from the framer to the output
    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [3:0] opcode_code;
        status_t    frame_status;
        logic       end_of_frame;
    } res_t;

    // crc contribution of the low nibble of crc ^ byte
    function automatic logic [7:0] crc_lo_nib(input logic [3:0] n);
        logic [7:0] r;
        unique case (n)
            4'h0: r = 8'h00;
            4'h1: r = 8'h5E;
            4'h2: r = 8'hBC;
            4'h3: r = 8'hE2;
            4'h4: r = 8'h61;
            4'h5: r = 8'h3F;
            4'h6: r = 8'hDD;
            4'h7: r = 8'h83;
            4'h8: r = 8'hC2;
            4'h9: r = 8'h9C;
            4'hA: r = 8'h7E;
            4'hB: r = 8'h20;
            4'hC: r = 8'hA3;
            4'hD: r = 8'hFD;
            4'hE: r = 8'h1F;
            default: r = 8'h41;
        endcase
        return r;
    endfunction

    // crc contribution of the high nibble of crc ^ byte
    function automatic logic [7:0] crc_hi_nib(input logic [3:0] n);
        logic [7:0] r;
        unique case (n)
            4'h0: r = 8'h00;
            4'h1: r = 8'h9D;
            4'h2: r = 8'h23;
            4'h3: r = 8'hBE;
            4'h4: r = 8'h46;
            4'h5: r = 8'hDB;
            4'h6: r = 8'h65;
            4'h7: r = 8'hF8;
            4'h8: r = 8'h8C;
            4'h9: r = 8'h11;
            4'hA: r = 8'hAF;
            4'hB: r = 8'h32;
            4'hC: r = 8'hCA;
            4'hD: r = 8'h57;
            4'hE: r = 8'hE9;
            default: r = 8'h74;
        endcase
        return r;
    endfunction

    // reflected crc-8 (poly 0x31) update by one byte
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc ^ b;
        return crc_lo_nib(x[3:0]) ^ crc_hi_nib(x[7:4]);
    endfunction

endpackage

`default_nettype wire

@@ design/ccfd_front.sv @@
// framer: follows the frame phase, runs the crc and builds result items
`default_nettype none

module ccfd_front import ccfd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_fire,
    input  wire logic        in_cmd,
    input  wire logic [7:0]  in_byte,
    input  wire logic [7:0]  frame_tag,
    input  wire logic [15:0] enabled_opcodes,
    output logic             push,
    output res_t             push_data
);

    phase_t     phase_reg, phase_next;
    logic [7:0] tag_reg, tag_next;
    logic [7:0] opcode_reg, opcode_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] crc_upd;
    logic [7:0] left_dec;
    logic [3:0] op_lo;
    logic [3:0] op_hi;
    status_t    status;

    assign crc_upd  = crc_update(crc_reg, in_byte);
    assign left_dec = left_reg - 8'd1;
    assign op_lo    = opcode_reg[3:0];
    assign op_hi    = opcode_reg[7:4];

    // verdict, checks in priority order
    always_comb begin
        priority if (tag_reg != frame_tag) begin
            status = ST_BAD_TAG;
        end else if (crc_reg != in_byte) begin
            status = ST_BAD_CRC;
        end else if (op_lo != op_hi) begin
            status = ST_NIB_DIFF;
        end else if (!enabled_opcodes[op_lo]) begin
            status = ST_UNHANDLED;
        end else begin
            status = ST_OK;
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (in_fire) begin
            if (in_cmd) begin
                phase_next = PH_TAG;
            end else begin
                unique case (phase_reg)
                    PH_OPCODE:  phase_next = PH_LENGTH;
                    PH_LENGTH:  phase_next = (in_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
                    PH_PAYLOAD: phase_next = (left_dec == 8'd0) ? PH_CRC : PH_PAYLOAD;
                    PH_CRC:     phase_next = PH_TAG;
                    default:    phase_next = PH_OPCODE;
                endcase
            end
        end
    end

    // header bytes, counters, crc and the result item
    always_comb begin
        tag_next    = tag_reg;
        opcode_next = opcode_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        push        = 1'b0;
        push_data   = '{kind: KIND_PAYLOAD, payload_byte: in_byte, payload_index: pos_reg,
                        opcode_code: op_lo, frame_status: ST_OK, end_of_frame: 1'b0};
        if (in_fire) begin
            if (in_cmd) begin
                tag_next    = 8'd0;
                opcode_next = 8'd0;
                left_next   = 8'd0;
                pos_next    = 8'd0;
                crc_next    = 8'd0;
            end else begin
                unique case (phase_reg)
                    PH_OPCODE: begin
                        opcode_next = in_byte;
                        crc_next    = crc_upd;
                    end
                    PH_LENGTH: begin
                        left_next = in_byte;
                        pos_next  = 8'd0;
                        crc_next  = crc_upd;
                    end
                    PH_PAYLOAD: begin
                        crc_next  = crc_upd;
                        pos_next  = pos_reg + 8'd1;
                        left_next = left_dec;
                        push      = 1'b1;
                    end
                    PH_CRC: begin
                        push        = 1'b1;
                        push_data   = '{kind: KIND_VERDICT, payload_byte: 8'd0,
                                        payload_index: 8'd0, opcode_code: op_lo,
                                        frame_status: status, end_of_frame: 1'b1};
                        tag_next    = 8'd0;
                        opcode_next = 8'd0;
                        left_next   = 8'd0;
                        pos_next    = 8'd0;
                        crc_next    = 8'd0;
                    end
                    default: begin
                        // any first byte is taken as the tag
                        tag_next    = in_byte;
                        opcode_next = 8'd0;
                        left_next   = 8'd0;
                        pos_next    = 8'd0;
                        crc_next    = crc_update(8'd0, in_byte);
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TAG;
            tag_reg    <= 8'd0;
            opcode_reg <= 8'd0;
            left_reg   <= 8'd0;
            pos_reg    <= 8'd0;
            crc_reg    <= 8'd0;
        end else begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            opcode_reg <= opcode_next;
            left_reg   <= left_next;
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
        end
    end

endmodule

`default_nettype wire

@@ design/ccfd_queue.sv @@
// short result queue between the framer and the output stage
`default_nettype none

module ccfd_queue import ccfd_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire res_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output res_t      head
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    res_t            slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full      = (count_reg == FullCnt);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ design/ccfd_back.sv @@
// output stage: holds one result item for the downstream handshake
`default_nettype none

module ccfd_back import ccfd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_not_empty,
    input  wire res_t q_head,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_data
);

    logic valid_reg;
    res_t data_reg;

    // take the queue head when the output slot is free or being emptied
    assign q_pop     = q_not_empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_head;
        end
    end

endmodule

`default_nettype wire

@@ design/crc8_checked_frame_deframer.sv @@
// top level of the crc-8 checked length-prefixed frame deframer
//
// channel   direction  tdata                                         tuser  tlast
// s_axis    in         byte_value[7:0]                               cmd    -
// m_axis    out        payload_byte, payload_index, opcode_code,     kind   end_of_frame
//                      frame_status (lowest bit first)
// cfg       in         index 0 frame_tag, index 1 enabled_opcodes, plain write
//
// one byte is accepted every cycle while the queue is not full, updating phase and crc.
// a result reaches m_axis through a queue slot, then the output register.
// s_axis_tready drops only when the result queue is full, i.e. after a downstream stall.
// reset is synchronous and active low; it restores the register defaults and the tag phase.
`default_nettype none

module crc8_checked_frame_deframer import ccfd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [InDataW-1:0]   s_axis_tdata,   // [7:0] byte_value
    input  wire logic                 s_axis_tuser,   // [0] cmd
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [OutDataW-1:0]       m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                                      // [19:16] opcode_code, [22:20] frame_status
    output logic                      m_axis_tuser,   // [0] kind
    output logic                      m_axis_tlast,   // end_of_frame
    // configuration writes
    input  wire logic                 cfg_we,
    input  wire logic [CfgIdxW-1:0]   cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_wdata
);

    logic [7:0]  frame_tag_reg;
    logic [15:0] enabled_opcodes_reg;
    logic        in_fire;
    logic        push;
    res_t        push_data;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    res_t        q_head;
    res_t        out_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_tag_reg       <= FRAME_TAG_RESET;
            enabled_opcodes_reg <= ENABLED_OPCODES_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_TAG:       frame_tag_reg       <= cfg_wdata[7:0];
                CFG_ENABLED_OPCODES: enabled_opcodes_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    ccfd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_fire         (in_fire),
        .in_cmd          (s_axis_tuser),
        .in_byte         (s_axis_tdata[7:0]),
        .frame_tag       (frame_tag_reg),
        .enabled_opcodes (enabled_opcodes_reg),
        .push            (push),
        .push_data       (push_data)
    );

    ccfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ccfd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (out_data)
    );

    // pack the result item onto the stream
    assign m_axis_tdata = {1'b0, out_data.frame_status, out_data.opcode_code,
                           out_data.payload_index, out_data.payload_byte};
    assign m_axis_tuser = out_data.kind;
    assign m_axis_tlast = out_data.end_of_frame;

endmodule

`default_nettype wire
